[hdl/aip_pkg.sv]
// ----------------------------------------------------------------------------
// aip_pkg
// Shared types, character codes and helpers for the ASCII integer parser.
// ----------------------------------------------------------------------------
`default_nettype none

package aip_pkg;

    // Default widths of the result fields
    localparam int DEFAULT_VALUE_WIDTH = 32;
    localparam int DEFAULT_COUNT_WIDTH = 16;

    // Field widths fixed by the interface
    localparam int CHAR_W   = 8;
    localparam int BASE_W   = 5;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RADIX       = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SIGNED_MODE = 1'b1;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;  // '0'
    localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;  // '9'
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;  // 'A'
    localparam logic [CHAR_W-1:0] CH_UPPER_F = 8'h46;  // 'F'
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;  // 'a'
    localparam logic [CHAR_W-1:0] CH_LOWER_F = 8'h66;  // 'f'
    localparam logic [CHAR_W-1:0] CH_UPPER_X = 8'h58;  // 'X'
    localparam logic [CHAR_W-1:0] CH_LOWER_X = 8'h78;  // 'x'
    localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;  // '-'

    // Bases
    localparam logic [BASE_W-1:0] BASE_AUTO = 5'd0;
    localparam logic [BASE_W-1:0] BASE_OCT  = 5'd8;
    localparam logic [BASE_W-1:0] BASE_DEC  = 5'd10;
    localparam logic [BASE_W-1:0] BASE_HEX  = 5'd16;

    // Digit code for a character that is no hex digit (above every base)
    localparam logic [BASE_W-1:0] NOT_DIGIT = 5'd31;

    // Parse phase, one-hot
    typedef enum logic [5:0] {
        PH_IDLE      = 6'b000001,
        PH_NUMSTART  = 6'b000010,
        PH_ZERO_AUTO = 6'b000100,
        PH_X_AUTO    = 6'b001000,
        PH_ZERO_HEX  = 6'b010000,
        PH_DIGITS    = 6'b100000
    } t_phase;

    // Map a character to its hex digit value, NOT_DIGIT otherwise
    function automatic logic [BASE_W-1:0] digit_value(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] off;
        off = '0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            off = c - CH_ZERO;
            return off[BASE_W-1:0];
        end
        if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
            off = c - CH_UPPER_A + 8'd10;
            return off[BASE_W-1:0];
        end
        if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
            off = c - CH_LOWER_A + 8'd10;
            return off[BASE_W-1:0];
        end
        return NOT_DIGIT;
    endfunction

    function automatic logic is_x(input logic [CHAR_W-1:0] c);
        return (c == CH_UPPER_X) || (c == CH_LOWER_X);
    endfunction

endpackage

`default_nettype wire

[hdl/ascii_integer_parser.sv]
// ----------------------------------------------------------------------------
// ascii_integer_parser
// Converts a character stream into an integer value and a consumed count.
// ----------------------------------------------------------------------------
//  channel  | handshake                    | payload
//  ---------+------------------------------+-----------------------------------
//  input    | i_in_valid / o_in_ready      | i_char_code, i_first_char
//  result   | o_out_valid / i_out_ready    | o_parsed_value, o_consumed_count
//  config   | i_cfg_we                     | i_cfg_index, i_cfg_data
//
//  One character word per cycle: the next state is formed by one multiply-add
//  (value times base plus digit) on the state registers; a result takes the
//  held value, negated for a sign, from the state registers.
//  A result shows in the cycle after the ending character is taken.
//  Input stalls only while the result register is full and not being taken.
//  Reset (synchronous, active low) clears the parse state, the result valid
//  and the configuration (radix detect, unsigned).
// ----------------------------------------------------------------------------
`default_nettype none

module ascii_integer_parser #(
    parameter int VALUE_WIDTH = aip_pkg::DEFAULT_VALUE_WIDTH,
    parameter int COUNT_WIDTH = aip_pkg::DEFAULT_COUNT_WIDTH
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // character input
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [aip_pkg::CHAR_W-1:0]      i_char_code,
    input  wire logic                            i_first_char,
    // result output
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [VALUE_WIDTH-1:0]               o_parsed_value,
    output logic [COUNT_WIDTH-1:0]               o_consumed_count,
    // configuration
    input  wire logic                            i_cfg_we,
    input  wire logic [aip_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [aip_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    import aip_pkg::*;

    // Configuration registers
    logic [BASE_W-1:0]      r_radix;
    logic                   r_signed_mode;

    // Parse state
    t_phase                 r_phase,  n_phase;
    logic [VALUE_WIDTH-1:0] r_acc,    n_acc;
    logic [BASE_W-1:0]      r_base,   n_base;
    logic [COUNT_WIDTH-1:0] r_count,  n_count;
    logic                   r_neg,    n_neg;

    // Result register
    logic                   r_out_valid;
    logic [VALUE_WIDTH-1:0] r_value,  n_value;
    logic [COUNT_WIDTH-1:0] r_cnt_out, n_cnt_out;

    // Working signals
    t_phase                 e_phase;
    logic [VALUE_WIDTH-1:0] e_acc;
    logic [BASE_W-1:0]      e_base;
    logic [COUNT_WIDTH-1:0] e_count;
    logic                   e_neg;
    logic [BASE_W-1:0]      start_base;
    logic [BASE_W-1:0]      digit;
    logic [BASE_W-1:0]      base_d;
    logic [COUNT_WIDTH-1:0] count_d;
    logic [COUNT_WIDTH-1:0] count_d_inc;
    logic [COUNT_WIDTH-1:0] e_count_inc;
    logic [VALUE_WIDTH-1:0] mac;
    logic                   go_digit;
    logic                   done;
    logic                   in_fire;

    // Saturating increment of a count
    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
        return (&c) ? c : c + COUNT_WIDTH'(1);
    endfunction

    assign in_fire    = i_in_valid && o_in_ready;
    assign o_in_ready = !r_out_valid || i_out_ready;

    assign start_base  = (r_radix > BASE_HEX) ? BASE_HEX : r_radix;
    assign digit       = digit_value(i_char_code);
    assign e_count_inc = sat_inc(e_count);
    assign count_d_inc = sat_inc(count_d);
    assign mac         = e_acc * VALUE_WIDTH'(base_d) + VALUE_WIDTH'(digit);

    // Start a fresh string on the first character
    always_comb begin
        if (i_first_char) begin
            e_phase = PH_NUMSTART;
            e_acc   = '0;
            e_base  = start_base;
            e_count = '0;
            e_neg   = 1'b0;
        end else begin
            e_phase = r_phase;
            e_acc   = r_acc;
            e_base  = r_base;
            e_count = r_count;
            e_neg   = r_neg;
        end
    end

    // Next parse state and result
    always_comb begin
        n_phase   = e_phase;
        n_acc     = e_acc;
        n_base    = e_base;
        n_count   = e_count;
        n_neg     = e_neg;
        base_d    = e_base;
        count_d   = e_count;
        go_digit  = 1'b0;
        done      = 1'b0;

        if (i_first_char && r_signed_mode && i_char_code == CH_MINUS) begin
            // take the sign
            n_neg   = 1'b1;
            n_count = e_count_inc;
        end else begin
            unique case (e_phase)
                PH_IDLE: begin
                    // ignore stray characters
                end
                PH_X_AUTO: begin
                    if (digit == NOT_DIGIT) begin
                        done = 1'b1;
                    end else begin
                        base_d   = BASE_HEX;
                        count_d  = e_count_inc;
                        go_digit = 1'b1;
                    end
                end
                PH_ZERO_HEX: begin
                    if (is_x(i_char_code)) begin
                        n_count = e_count_inc;
                        n_phase = PH_DIGITS;
                    end else begin
                        go_digit = 1'b1;
                    end
                end
                PH_ZERO_AUTO: begin
                    if (is_x(i_char_code)) begin
                        n_phase = PH_X_AUTO;
                    end else begin
                        base_d   = BASE_OCT;
                        go_digit = 1'b1;
                    end
                end
                PH_NUMSTART: begin
                    if (e_base == BASE_AUTO && i_char_code == CH_ZERO) begin
                        n_count = e_count_inc;
                        n_base  = BASE_OCT;
                        n_phase = PH_ZERO_AUTO;
                    end else if (e_base == BASE_AUTO) begin
                        base_d   = BASE_DEC;
                        go_digit = 1'b1;
                    end else if (e_base == BASE_HEX && i_char_code == CH_ZERO) begin
                        n_count = e_count_inc;
                        n_phase = PH_ZERO_HEX;
                    end else begin
                        go_digit = 1'b1;
                    end
                end
                PH_DIGITS: begin
                    go_digit = 1'b1;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase

            // accumulate a digit or end the number
            if (go_digit) begin
                n_base = base_d;
                if (digit < base_d) begin
                    n_acc   = mac;
                    n_count = count_d_inc;
                    n_phase = PH_DIGITS;
                end else begin
                    done = 1'b1;
                end
            end
        end

        if (done) begin
            n_phase = PH_IDLE;
        end
        n_value   = e_neg ? (VALUE_WIDTH'(0) - e_acc) : e_acc;
        n_cnt_out = count_d;
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix       <= BASE_AUTO;
            r_signed_mode <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_RADIX:       r_radix       <= i_cfg_data;
                REG_SIGNED_MODE: r_signed_mode <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Advance the parse state on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_acc   <= '0;
            r_base  <= BASE_AUTO;
            r_count <= '0;
            r_neg   <= 1'b0;
        end else if (in_fire) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_base  <= n_base;
            r_count <= n_count;
            r_neg   <= n_neg;
        end
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire && done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && done) begin
            r_value   <= n_value;
            r_cnt_out <= n_cnt_out;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_parsed_value   = r_value;
    assign o_consumed_count = r_cnt_out;

endmodule

`default_nettype wire

[hdl/aip_checker.sv]
// ----------------------------------------------------------------------------
// aip_checker
// Port-level checks for the ASCII integer parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module aip_checker #(
    parameter int VALUE_WIDTH = aip_pkg::DEFAULT_VALUE_WIDTH,
    parameter int COUNT_WIDTH = aip_pkg::DEFAULT_COUNT_WIDTH
) (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_in_valid,
    input wire logic                   o_in_ready,
    input wire logic                   o_out_valid,
    input wire logic                   i_out_ready,
    input wire logic [VALUE_WIDTH-1:0] o_parsed_value,
    input wire logic [COUNT_WIDTH-1:0] o_consumed_count
);

    // Reset empties the result register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A stalled result holds its word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_parsed_value) && $stable(o_consumed_count)))
        else $error("stalled result changed");

    // Input stalls only behind a blocked result
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) == !o_in_ready)
        else $error("input ready does not follow result register");

    // A new result needs an accepted character the cycle before
    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready))
        else $error("result without an accepted word");

endmodule

bind ascii_integer_parser aip_checker #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .COUNT_WIDTH(COUNT_WIDTH)
) u_aip_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_parsed_value  (o_parsed_value),
    .o_consumed_count(o_consumed_count)
);

`default_nettype wire
